/* design/vefe_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the microcode rom of the voxel exposed-face emitter
// no dependencies; every other module of the block but vefe_ram imports this package

package vefe_pkg;

	localparam int DIM_BITS    = 5;
	localparam int TYPE_BITS   = 8;
	localparam int DIM_SIZE    = 1 << DIM_BITS;
	localparam int ADDR_W      = 3 * DIM_BITS;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int VALUE_W     = 8;
	localparam int EXT_W       = 6;
	localparam int COORD_W     = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int PC_W        = 5;
	localparam int NUM_FACES   = 6;
	localparam int FACE_W      = 3;
	localparam int TRI_VERTS   = 3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MESH  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = CFG_IDX_W'(3);

	localparam logic [CFG_DATA_W-1:0] TARGET_RST = CFG_DATA_W'(1);
	localparam logic [EXT_W-1:0]      EXT_RST    = EXT_W'(32);

	localparam logic [1:0] PLANE_YZ = 2'd0;
	localparam logic [1:0] PLANE_XZ = 2'd1;
	localparam logic [1:0] PLANE_XY = 2'd2;

	localparam logic [FACE_W-1:0] FACE_LEFT   = FACE_W'(0);
	localparam logic [FACE_W-1:0] FACE_RIGHT  = FACE_W'(1);
	localparam logic [FACE_W-1:0] FACE_FRONT  = FACE_W'(2);
	localparam logic [FACE_W-1:0] FACE_BACK   = FACE_W'(3);
	localparam logic [FACE_W-1:0] FACE_BOTTOM = FACE_W'(4);
	localparam logic [FACE_W-1:0] FACE_TOP    = FACE_W'(5);

	// vertex offsets {dx, dy, down}, two triangles per face
	localparam logic [2:0] FACE_VERTS [NUM_FACES][2*TRI_VERTS] = '{
		'{3'b001, 3'b000, 3'b010, 3'b010, 3'b011, 3'b001},
		'{3'b101, 3'b111, 3'b110, 3'b110, 3'b100, 3'b101},
		'{3'b001, 3'b101, 3'b100, 3'b100, 3'b000, 3'b001},
		'{3'b111, 3'b011, 3'b010, 3'b010, 3'b110, 3'b111},
		'{3'b011, 3'b111, 3'b101, 3'b101, 3'b001, 3'b011},
		'{3'b000, 3'b100, 3'b110, 3'b110, 3'b010, 3'b000}
	};

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_END  = PC_W'(20);

	typedef struct packed {
		logic                 op;
		logic [DIM_BITS-1:0]  pos_x;
		logic [DIM_BITS-1:0]  pos_y;
		logic [DIM_BITS-1:0]  pos_z;
		logic [VALUE_W-1:0]   tile_value;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] ax;
		logic [COORD_W-1:0] ay;
		logic [COORD_W-1:0] az;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
		logic [COORD_W-1:0] bz;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		logic [1:0]         plane;
		logic               last;
	} face_tri_t;

	typedef enum logic [2:0] {
		NB_CENTER,
		NB_LEFT,
		NB_RIGHT,
		NB_FRONT,
		NB_BACK,
		NB_BOTTOM,
		NB_TOP
	} nbr_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_SKIP,
		J_NOMATCH,
		J_NOFACE
	} jcond_t;

	typedef struct packed {
		logic              rd;
		nbr_t              rd_nbr;
		logic              cap;
		logic [FACE_W-1:0] cap_face;
		logic              wr;
		logic              emit;
		logic [FACE_W-1:0] face;
		logic              tri_hi;
		jcond_t            jmp;
		pc_t               jmp_to;
		logic              done;
	} ucode_t;

	typedef struct packed {
		logic                 skip;
		logic                 nomatch;
		logic [NUM_FACES-1:0] exposed;
		logic                 blocked;
	} seq_stat_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              wr;
		logic              rd;
		nbr_t              rd_nbr;
		logic              cap;
		logic [FACE_W-1:0] cap_face;
		logic              emit;
		logic [FACE_W-1:0] face;
		logic              tri_hi;
	} seq_cmd_t;

	function automatic ucode_t uw(logic rd, nbr_t rn, logic cap, logic [FACE_W-1:0] cf,
			logic wr, logic em, logic [FACE_W-1:0] f, logic th, jcond_t j, pc_t jt,
			logic dn);
		ucode_t u;
		u.rd       = rd;
		u.rd_nbr   = rn;
		u.cap      = cap;
		u.cap_face = cf;
		u.wr       = wr;
		u.emit     = em;
		u.face     = f;
		u.tri_hi   = th;
		u.jmp      = j;
		u.jmp_to   = jt;
		u.done     = dn;
		return u;
	endfunction

	// program: check and center read, six neighbor reads, twelve emit steps, close
	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t u;
		unique case (pc)
			PC_W'(0):  u = uw(1'b1, NB_CENTER, 1'b0, FACE_LEFT,   1'b1, 1'b0, FACE_LEFT,
					1'b0, J_SKIP, PC_END, 1'b0);
			PC_W'(1):  u = uw(1'b1, NB_LEFT,   1'b0, FACE_LEFT,   1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NOMATCH, PC_END, 1'b0);
			PC_W'(2):  u = uw(1'b1, NB_RIGHT,  1'b1, FACE_LEFT,   1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(3):  u = uw(1'b1, NB_FRONT,  1'b1, FACE_RIGHT,  1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(4):  u = uw(1'b1, NB_BACK,   1'b1, FACE_FRONT,  1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(5):  u = uw(1'b1, NB_BOTTOM, 1'b1, FACE_BACK,   1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(6):  u = uw(1'b1, NB_TOP,    1'b1, FACE_BOTTOM, 1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(7):  u = uw(1'b0, NB_CENTER, 1'b1, FACE_TOP,    1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b0);
			PC_W'(8):  u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_LEFT,
					1'b0, J_NOFACE, PC_W'(10), 1'b0);
			PC_W'(9):  u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_LEFT,
					1'b1, J_NONE, PC_END, 1'b0);
			PC_W'(10): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_RIGHT,
					1'b0, J_NOFACE, PC_W'(12), 1'b0);
			PC_W'(11): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_RIGHT,
					1'b1, J_NONE, PC_END, 1'b0);
			PC_W'(12): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_FRONT,
					1'b0, J_NOFACE, PC_W'(14), 1'b0);
			PC_W'(13): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_FRONT,
					1'b1, J_NONE, PC_END, 1'b0);
			PC_W'(14): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_BACK,
					1'b0, J_NOFACE, PC_W'(16), 1'b0);
			PC_W'(15): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_BACK,
					1'b1, J_NONE, PC_END, 1'b0);
			PC_W'(16): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_BOTTOM,
					1'b0, J_NOFACE, PC_W'(18), 1'b0);
			PC_W'(17): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_BOTTOM,
					1'b1, J_NONE, PC_END, 1'b0);
			PC_W'(18): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_TOP,
					1'b0, J_NOFACE, PC_END, 1'b0);
			PC_W'(19): u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b1, FACE_TOP,
					1'b1, J_NONE, PC_END, 1'b0);
			default:   u = uw(1'b0, NB_CENTER, 1'b0, FACE_LEFT, 1'b0, 1'b0, FACE_LEFT,
					1'b0, J_NONE, PC_END, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic [1:0] face_plane(logic [FACE_W-1:0] f);
		logic [1:0] p;
		unique case (f) inside
			FACE_LEFT, FACE_RIGHT:  p = PLANE_YZ;
			FACE_FRONT, FACE_BACK:  p = PLANE_XZ;
			default:                p = PLANE_XY;
		endcase
		return p;
	endfunction

	// extents above the store size count as the full store
	function automatic logic [EXT_W-1:0] ext_clamp(logic [EXT_W-1:0] v);
		logic [EXT_W-1:0] r;
		r = v;
		if (32'(v) > DIM_SIZE) r = EXT_W'(DIM_SIZE);
		return r;
	endfunction

endpackage

/* design/voxel_exposed_face_emitter.sv */
`timescale 1ns / 1ps
// Voxel exposed-face emitter, top level: sequencer plus datapath.
// Depends on vefe_pkg, vefe_seq, vefe_datapath (which holds vefe_ram).
//
// Usage. The input channel (in_valid/in_ready/in_data) takes one item per beat:
// a write stores tile_value at (pos_x, pos_y, pos_z); a mesh tests that tile
// against target_type and, for every face the face tests find exposed, sends two
// triangles on the output channel (out_valid/out_ready/out_data) in the order
// left, right, front, back, bottom, top, with last set on the final one. The
// configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while the block is idle.
// Timing. A write or an out-of-grid item goes from the first step straight to
// the closing step, and a mesh of another tile type does so after the tile
// check. A matching mesh runs the store reads and face tests (seven reads on
// one read port), then an emit step per triangle of each exposed face, with a
// step that jumps past each hidden face, then the closing step.
// Reset clears the configuration to its defaults and starts a sweep that
// zeroes the 32768-entry store, one entry a cycle; in_ready stays low for
// the whole sweep while configuration writes are still taken. A stalled
// receiver holds the sequencer on its current emit step; the output register
// keeps the pending triangle, and the next item is taken once the last
// triangle of the current one is in that register.

module voxel_exposed_face_emitter
	import vefe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  item_t                 in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output face_tri_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	seq_cmd_t  cmd;
	seq_stat_t stat;
	logic      clearing;
	logic      start;

	// a new beat may enter in the closing step of the previous item
	assign in_ready  = ~clearing & (~cmd.busy | cmd.done);
	assign start     = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	vefe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd)
	);

	vefe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (in_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* design/vefe_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies

module vefe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/vefe_seq.sv */
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on vefe_pkg (rom contents, control and status structs)

module vefe_seq
	import vefe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  seq_stat_t stat,
	output seq_cmd_t  cmd
);

	pc_t    pc_q;
	logic   busy_q;
	pc_t    pc_d;
	logic   busy_d;
	ucode_t uc;
	logic   face_ok;
	logic   hold;
	logic   jump;

	assign uc = ucode_rom(pc_q);

	always_comb begin
		face_ok = stat.exposed[uc.face];
		// an emit step waits while the output register is full and out_ready is low
		hold    = busy_q & uc.emit & face_ok & stat.blocked;

		unique case (uc.jmp)
			J_NONE:    jump = 1'b0;
			J_SKIP:    jump = stat.skip;
			J_NOMATCH: jump = stat.nomatch;
			J_NOFACE:  jump = ~face_ok;
			default:   jump = 1'b0;
		endcase

		pc_d   = pc_q;
		busy_d = busy_q;
		if (start) begin
			busy_d = 1'b1;
			pc_d   = '0;
		end else if (busy_q && !hold) begin
			if (uc.done) begin
				busy_d = 1'b0;
				pc_d   = '0;
			end else if (jump) begin
				pc_d = uc.jmp_to;
			end else begin
				pc_d = pc_q + PC_W'(1);
			end
		end

		cmd.busy     = busy_q;
		cmd.done     = busy_q & uc.done;
		cmd.wr       = busy_q & uc.wr;
		cmd.rd       = busy_q & uc.rd;
		cmd.rd_nbr   = uc.rd_nbr;
		cmd.cap      = busy_q & uc.cap;
		cmd.cap_face = uc.cap_face;
		cmd.emit     = busy_q & uc.emit & face_ok & ~stat.blocked;
		cmd.face     = uc.face;
		cmd.tri_hi   = uc.tri_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else begin
			busy_q <= busy_d;
			pc_q   <= pc_d;
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= PC_END)
		else $error("step counter ran past the end of the program");

	a_idle_pc_home: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> pc_q == '0)
		else $error("step counter not at entry while idle");

endmodule

/* design/vefe_datapath.sv */
`timescale 1ns / 1ps
// datapath: item and config registers, tile store with clearing sweep, face
// tests, triangle builder and output register; depends on vefe_pkg, vefe_ram
module vefe_datapath
	import vefe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  seq_cmd_t              cmd,
	output seq_stat_t             stat,
	output logic                  clearing,
	output logic                  out_valid,
	input  logic                  out_ready,
	output face_tri_t             out_data
);

	item_t                  item_q;
	logic [CFG_DATA_W-1:0]  target_q;
	logic [EXT_W-1:0]       width_q;
	logic [EXT_W-1:0]       height_q;
	logic [EXT_W-1:0]       depth_q;
	logic                   clearing_q;
	logic [ADDR_W-1:0]      clr_cnt_q;
	logic [NUM_FACES-1:0]   exp_q;
	logic                   out_valid_q;
	face_tri_t              out_q;

	logic [EXT_W-1:0]       w_ext;
	logic [EXT_W-1:0]       h_ext;
	logic [EXT_W-1:0]       d_ext;
	logic                   in_grid;
	logic                   z_pos;
	logic                   nb_empty;
	logic                   cap_val;
	logic [DIM_BITS-1:0]    xa;
	logic [DIM_BITS-1:0]    ya;
	logic [DIM_BITS-1:0]    za;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [TYPE_BITS-1:0]   ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [TYPE_BITS-1:0]   ram_rdata;
	logic                   more;
	logic [2:0]             vcode [TRI_VERTS];
	logic [COORD_W-1:0]     vx [TRI_VERTS];
	logic [COORD_W-1:0]     vy [TRI_VERTS];
	logic [COORD_W-1:0]     vz [TRI_VERTS];
	face_tri_t              tri_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			width_q  <= EXT_RST;
			height_q <= EXT_RST;
			depth_q  <= EXT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TARGET_TYPE: target_q <= cfg_wdata;
				CFG_GRID_WIDTH:  width_q  <= EXT_W'(cfg_wdata);
				CFG_GRID_HEIGHT: height_q <= EXT_W'(cfg_wdata);
				CFG_GRID_DEPTH:  depth_q  <= EXT_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
	end

	// zero sweep over the whole store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (&clr_cnt_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clearing = clearing_q;

	always_comb begin
		w_ext   = ext_clamp(width_q);
		h_ext   = ext_clamp(height_q);
		d_ext   = ext_clamp(depth_q);
		in_grid = (32'(item_q.pos_x) < 32'(w_ext)) && (32'(item_q.pos_y) < 32'(h_ext))
			&& (32'(item_q.pos_z) < 32'(d_ext));

		xa = item_q.pos_x;
		ya = item_q.pos_y;
		za = item_q.pos_z;
		unique case (cmd.rd_nbr)
			NB_CENTER: ;
			NB_LEFT:   xa = item_q.pos_x - DIM_BITS'(1);
			NB_RIGHT:  xa = item_q.pos_x + DIM_BITS'(1);
			NB_FRONT:  ya = item_q.pos_y - DIM_BITS'(1);
			NB_BACK:   ya = item_q.pos_y + DIM_BITS'(1);
			NB_BOTTOM: za = item_q.pos_z - DIM_BITS'(1);
			NB_TOP:    za = item_q.pos_z + DIM_BITS'(1);
			default: ;
		endcase

		ram_we    = clearing_q | (cmd.wr & in_grid & (item_q.op == OP_WRITE));
		ram_waddr = clearing_q ? clr_cnt_q : {item_q.pos_z, item_q.pos_y, item_q.pos_x};
		ram_wdata = clearing_q ? '0 : TYPE_BITS'(item_q.tile_value);
		ram_re    = cmd.rd & (item_q.op == OP_MESH);
		ram_raddr = {za, ya, xa};
	end

	vefe_ram #(
		.WIDTH (TYPE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// neighbor tests on the beat read in the step before
	always_comb begin
		nb_empty = (ram_rdata == '0);
		z_pos    = (item_q.pos_z != '0);
		unique case (cmd.cap_face)
			FACE_LEFT:   cap_val = z_pos & (item_q.pos_x != '0) & nb_empty;
			FACE_RIGHT:  cap_val = z_pos & nb_empty
				& (32'(item_q.pos_x) + 32'(1) < 32'(w_ext));
			FACE_FRONT:  cap_val = z_pos & (item_q.pos_y != '0) & nb_empty;
			FACE_BACK:   cap_val = z_pos & nb_empty
				& (32'(item_q.pos_y) + 32'(1) < 32'(h_ext));
			FACE_BOTTOM: cap_val = z_pos & nb_empty;
			FACE_TOP:    cap_val = nb_empty
				| (32'(item_q.pos_z) + 32'(1) >= 32'(d_ext));
			default:     cap_val = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (cmd.cap) begin
			exp_q[cmd.cap_face] <= cap_val;
		end
	end

	always_comb begin
		stat.skip    = ~in_grid | (item_q.op == OP_WRITE);
		stat.nomatch = (ram_rdata != TYPE_BITS'(target_q));
		stat.exposed = exp_q;
		stat.blocked = out_valid_q & ~out_ready;
	end

	always_comb begin
		more = 1'b0;
		for (int i = 0; i < NUM_FACES; i++) begin
			if (FACE_W'(i) > cmd.face && exp_q[i]) more = 1'b1;
		end
		for (int v = 0; v < TRI_VERTS; v++) begin
			vcode[v] = FACE_VERTS[cmd.face][(cmd.tri_hi ? 3'd3 : 3'd0) + 3'(v)];
			vx[v]    = COORD_W'(item_q.pos_x) + COORD_W'(vcode[v][2]);
			vy[v]    = COORD_W'(item_q.pos_y) + COORD_W'(vcode[v][1]);
			vz[v]    = COORD_W'(item_q.pos_z) - COORD_W'(vcode[v][0]);
		end
		tri_d.ax    = vx[0];
		tri_d.ay    = vy[0];
		tri_d.az    = vz[0];
		tri_d.bx    = vx[1];
		tri_d.by    = vy[1];
		tri_d.bz    = vz[1];
		tri_d.cx    = vx[2];
		tri_d.cy    = vy[2];
		tri_d.cz    = vz[2];
		tri_d.plane = face_plane(cmd.face);
		tri_d.last  = cmd.tri_hi & ~more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= tri_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and write in the same cycle");

	a_clear_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !cmd.busy)
		else $error("sequencer active during the clearing sweep");

	a_more_after_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !tri_d.last |=> cmd.busy)
		else $error("sequencer stopped before the last triangle");

endmodule
